// ----- src/mbt_pkg.sv -----
`timescale 1ns / 1ps

package mbt_pkg;

   // Request commands.
   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_TEMPO_UP = 2'd1;
   localparam logic [1:0] CMD_TEMPO_DN = 2'd2;
   localparam logic [1:0] CMD_SET      = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CLOCK_HZ  = 2'd0;
   localparam logic [1:0] CSR_BEAT_MS   = 2'd1;
   localparam logic [1:0] CSR_START_BPM = 2'd2;

   // Divider select codes.
   localparam logic [1:0] DIV_64   = 2'd0;
   localparam logic [1:0] DIV_256  = 2'd1;
   localparam logic [1:0] DIV_1024 = 2'd2;

   localparam int CSR_DATA_W = 27;
   localparam int BPM_W      = 10;

   localparam logic [26:0] CLOCK_HZ_RST  = 27'd16000000;
   localparam logic [12:0] BEAT_MS_RST   = 13'd50;
   localparam logic [9:0]  START_BPM_RST = 10'd60;

   localparam logic [9:0] BPM_MIN    = 10'd1;
   localparam logic [9:0] BPM_MAX    = 10'd1023;
   localparam logic [9:0] BPM_SLOW   = 10'd57;
   localparam logic [9:0] BPM_MEDIUM = 10'd228;

   // Shared divider widths: dividend, divisor, and the ms to counts scale.
   localparam int DVD_W = 34;
   localparam int DVS_W = 17;
   localparam logic [DVS_W-1:0] MS_SCALE = 17'd1000;

endpackage

// ----- src/mbt_channels.sv -----
`timescale 1ns / 1ps

interface mbt_req_if import mbt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       command;
   logic [BPM_W-1:0] bpm_value;

   modport source (output valid, command, bpm_value, input ready);
   modport sink   (input valid, command, bpm_value, output ready);
endinterface

interface mbt_rsp_if import mbt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             sound_on;
   logic             sound_off;
   logic [BPM_W-1:0] current_bpm;
   logic [1:0]       divider_select;
   logic [15:0]      period_top;

   modport source (output valid, sound_on, sound_off, current_bpm, divider_select,
                   period_top, input ready);
   modport sink   (input valid, sound_on, sound_off, current_bpm, divider_select,
                   period_top, output ready);
endinterface

// ----- src/metronome_beat_timer_top.sv -----
`timescale 1ns / 1ps
// Tick request: one per cycle while the result side keeps up; the result is valid next cycle.
// Tempo requests: one shared bit-serial divider runs twice (34 quotient bits for the period
// top, 34 for the sound length) with a setup state S_MID between and a final state S_FINAL
// after; the result is valid as S_FINAL ends, and the next request is taken back in S_IDLE.
// Reset (synchronous, active high) loads the default configuration and runs the same tempo
// load for 60 bpm; the first request is accepted once that load has returned to S_IDLE.
module metronome_beat_timer_top import mbt_pkg::*; #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   mbt_req_if.sink               req_bus,
   mbt_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int CB = COUNTER_BITS;
   localparam logic [DVD_W-1:0] MAXV = (DVD_W'(1) << CB) - DVD_W'(1);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_MID, S_FINAL} state_type;

   state_type        state_ff;
   logic             phase_ff;
   logic [5:0]       count_ff;
   logic             respond_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [39:0]      prod_ff;

   logic [26:0]      clock_hz_ff;
   logic [12:0]      beat_ms_ff;
   logic [9:0]       tempo_ff;
   logic [1:0]       div_code_ff;
   logic [9:0]       prescale_ff;
   logic [CB-1:0]    beat_count_ff;
   logic [CB-1:0]    wrap_top_ff;
   logic [CB-1:0]    sound_point_ff;

   logic             rsp_valid_ff;
   logic             rsp_on_ff;
   logic             rsp_off_ff;

   logic req_acc;
   logic csr_start;
   logic load_go;
   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_acc   = req_bus.valid && req_bus.ready;
   assign csr_start = csr_wr_en && (csr_index == CSR_START_BPM);
   assign load_go   = reset || csr_start || (req_acc && (req_bus.command != CMD_TICK));

   // Tempo load setup: clamp, divider choice and the operands of both divisions.
   logic [10:0]      ld_raw;
   logic [26:0]      ld_clk;
   logic [12:0]      ld_ms;
   logic [9:0]       ld_bpm;
   logic [1:0]       ld_code;
   logic [3:0]       ld_shift;
   logic [DVS_W-1:0] ld_den;
   logic [32:0]      ld_clk60;
   logic [DVD_W-1:0] ld_dvd;

   always_comb begin
      ld_clk = clock_hz_ff;
      ld_ms  = beat_ms_ff;
      if (reset) begin
         ld_raw = {1'b0, START_BPM_RST};
         ld_clk = CLOCK_HZ_RST;
         ld_ms  = BEAT_MS_RST;
      end else if (csr_start) begin
         ld_raw = {1'b0, csr_wr_data[BPM_W-1:0]};
      end else begin
         case (req_bus.command)
            CMD_TEMPO_UP: ld_raw = {1'b0, tempo_ff} + 11'd1;
            CMD_TEMPO_DN: ld_raw = {1'b0, tempo_ff} - 11'd1;
            CMD_SET:      ld_raw = {1'b0, req_bus.bpm_value};
            default:      ld_raw = {1'b0, tempo_ff};
         endcase
      end
      if (ld_raw == 11'd0) begin
         ld_bpm = BPM_MIN;
      end else if (ld_raw > {1'b0, BPM_MAX}) begin
         ld_bpm = BPM_MAX;
      end else begin
         ld_bpm = ld_raw[9:0];
      end
      if (ld_bpm < BPM_SLOW) begin
         ld_code = DIV_1024;
      end else if (ld_bpm < BPM_MEDIUM) begin
         ld_code = DIV_256;
      end else begin
         ld_code = DIV_64;
      end
      ld_shift = 4'd6 + {1'b0, ld_code, 1'b0};
      ld_den   = DVS_W'(ld_bpm) << ld_shift;
      ld_clk60 = {ld_clk, 6'b0} - {4'b0, ld_clk, 2'b0};
      // Rounded quotient: (2*num + den) / (2*den).
      ld_dvd   = {ld_clk60, 1'b0} + DVD_W'(ld_den);
   end

   // One restoring division step per cycle.
   logic [DVS_W:0]   dv_part;
   logic             dv_ge;
   logic [DVS_W:0]   dv_diff;
   logic [DVS_W-1:0] rem_in;
   logic [DVD_W-1:0] quo_in;

   always_comb begin
      dv_part = {rem_ff, quo_ff[DVD_W-1]};
      dv_ge   = dv_part >= {1'b0, dvs_ff};
      dv_diff = dv_part - {1'b0, dvs_ff};
      rem_in  = dv_ge ? dv_diff[DVS_W-1:0] : dv_part[DVS_W-1:0];
      quo_in  = {quo_ff[DVD_W-2:0], dv_ge};
   end

   // Period top from the rounded quotient, and the sound point from the count.
   logic [3:0]       cur_shift;
   logic [DVD_W-1:0] q_m1;
   logic [CB-1:0]    top_val;
   logic [DVD_W-1:0] top_p1;
   logic [DVD_W-1:0] pt_diff;
   logic [CB-1:0]    pt_val;

   always_comb begin
      cur_shift = 4'd6 + {1'b0, div_code_ff, 1'b0};
      q_m1      = (quo_ff == '0) ? '0 : quo_ff - DVD_W'(1);
      top_val   = (q_m1 > MAXV) ? MAXV[CB-1:0] : q_m1[CB-1:0];
      top_p1    = DVD_W'(wrap_top_ff) + DVD_W'(1);
      pt_diff   = top_p1 - quo_ff;
      if (quo_ff > top_p1) begin
         pt_val = '0;
      end else if (pt_diff > MAXV) begin
         pt_val = MAXV[CB-1:0];
      end else begin
         pt_val = pt_diff[CB-1:0];
      end
   end

   // Tick path.
   logic [9:0]    pre_in;
   logic          div_hit;
   logic [CB-1:0] beat_in;

   always_comb begin
      pre_in = prescale_ff + 10'd1;
      case (div_code_ff)
         DIV_64:   div_hit = (pre_in[5:0] == 6'd0);
         DIV_256:  div_hit = (pre_in[7:0] == 8'd0);
         DIV_1024: div_hit = (pre_in == 10'd0);
         default:  div_hit = (pre_in[5:0] == 6'd0);
      endcase
      if (!div_hit) begin
         beat_in = beat_count_ff;
      end else if (beat_count_ff == wrap_top_ff) begin
         beat_in = '0;
      end else begin
         beat_in = beat_count_ff + CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff  <= CLOCK_HZ_RST;
         beat_ms_ff   <= BEAT_MS_RST;
         prescale_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en && (csr_index == CSR_CLOCK_HZ)) begin
            clock_hz_ff <= csr_wr_data;
         end
         if (csr_wr_en && (csr_index == CSR_BEAT_MS)) begin
            beat_ms_ff <= csr_wr_data[12:0];
         end
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_acc && (req_bus.command == CMD_TICK)) begin
            prescale_ff   <= pre_in;
            beat_count_ff <= beat_in;
            rsp_on_ff     <= div_hit && (beat_in == sound_point_ff);
            rsp_off_ff    <= div_hit && (beat_in == wrap_top_ff);
            rsp_valid_ff  <= 1'b1;
         end
      end

      if (load_go) begin
         state_ff      <= S_DIV;
         phase_ff      <= 1'b0;
         count_ff      <= 6'(DVD_W - 1);
         respond_ff    <= !reset && !csr_start;
         tempo_ff      <= ld_bpm;
         div_code_ff   <= ld_code;
         beat_count_ff <= '0;
         quo_ff        <= ld_dvd;
         rem_ff        <= '0;
         dvs_ff        <= {ld_den[DVS_W-2:0], 1'b0};
         prod_ff       <= 40'(ld_ms) * 40'(ld_clk);
      end else begin
         case (state_ff)
            S_DIV: begin
               quo_ff   <= quo_in;
               rem_ff   <= rem_in;
               count_ff <= count_ff - 6'd1;
               if (count_ff == 6'd0) begin
                  state_ff <= phase_ff ? S_FINAL : S_MID;
               end
            end
            S_MID: begin
               // floor(ms*clk/(1000*div)) = floor(floor(ms*clk/div)/1000).
               wrap_top_ff <= top_val;
               quo_ff      <= DVD_W'(prod_ff >> cur_shift);
               rem_ff      <= '0;
               dvs_ff      <= MS_SCALE;
               count_ff    <= 6'(DVD_W - 1);
               phase_ff    <= 1'b1;
               state_ff    <= S_DIV;
            end
            S_FINAL: begin
               sound_point_ff <= pt_val;
               if (respond_ff) begin
                  rsp_on_ff    <= 1'b0;
                  rsp_off_ff   <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.sound_on       = rsp_on_ff;
   assign rsp_bus.sound_off      = rsp_off_ff;
   assign rsp_bus.current_bpm    = tempo_ff;
   assign rsp_bus.divider_select = div_code_ff;
   assign rsp_bus.period_top     = 16'(wrap_top_ff);

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_bus.command == CMD_TICK)) |=> rsp_valid_ff)
      else $error("tick request gave no result in the next cycle");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_bus.command != CMD_TICK)) |=> (state_ff == S_DIV))
      else $error("tempo request did not start the divider");

   a_beat_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (beat_count_ff <= wrap_top_ff))
      else $error("beat counter above period top");

   a_tempo_range: assert property (@(posedge clock) disable iff (reset)
      tempo_ff != 10'd0)
      else $error("tempo left its range");

   a_divider_match: assert property (@(posedge clock) disable iff (reset)
      (div_code_ff == DIV_1024) == (tempo_ff < BPM_SLOW))
      else $error("divider does not match tempo");

endmodule
